>>> src/jssd_pkg.sv
// Shared types, constants and codes for the job-shop schedule decoder.
package jssd_pkg;

    localparam int MAX_JOBS     = 16;
    localparam int MAX_MACHINES = 16;
    localparam int MAX_OPS      = 16;
    localparam int TIME_W       = 16;

    localparam int CMD_W    = 2;
    localparam int JOB_W    = 4;
    localparam int OP_W     = 4;
    localparam int MACH_W   = 4;
    localparam int DUR_W    = 8;
    localparam int SLOT_W   = 9;
    localparam int OPCNT_W  = 5;
    localparam int ROUTE_AW = JOB_W + OP_W;
    localparam int ROUTE_DEPTH = MAX_JOBS * MAX_OPS;
    localparam int ROUTE_DW = MACH_W + DUR_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SCHED = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        ALU_MAX    = 1'b0,
        ALU_SATADD = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FINISH,
        ST_FIRST,
        ST_SPAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [MACH_W-1:0] machine;
        logic [DUR_W-1:0]  duration;
    } route_t;

    typedef struct packed {
        logic              overrun;
        logic [TIME_W-1:0] makespan;
        logic [TIME_W-1:0] stop_time;
        logic [TIME_W-1:0] start_time;
        logic [SLOT_W-1:0] slot;
        logic [MACH_W-1:0] machine;
    } result_t;

endpackage

>>> src/jssd_route_ram.sv
// Routing table memory: one write port, one registered read port.
module jssd_route_ram (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [jssd_pkg::ROUTE_AW-1:0] waddr,
    input  jssd_pkg::route_t              wdata,
    input  logic                          re,
    input  logic [jssd_pkg::ROUTE_AW-1:0] raddr,
    output jssd_pkg::route_t              rdata
);

    jssd_pkg::route_t mem [jssd_pkg::ROUTE_DEPTH];
    jssd_pkg::route_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/jssd_alu.sv
// Shared time unit: maximum of two times or saturating time add.
module jssd_alu (
    input  jssd_pkg::alu_op_t             op,
    input  logic [jssd_pkg::TIME_W-1:0]   a,
    input  logic [jssd_pkg::TIME_W-1:0]   b,
    output logic [jssd_pkg::TIME_W-1:0]   y
);

    logic [jssd_pkg::TIME_W:0] sum;

    always_comb begin
        sum = {1'b0, a} + {1'b0, b};
        case (op)
            jssd_pkg::ALU_MAX:    y = (a > b) ? a : b;
            jssd_pkg::ALU_SATADD: y = sum[jssd_pkg::TIME_W] ? jssd_pkg::TIME_MAX
                                                             : sum[jssd_pkg::TIME_W-1:0];
            default:              y = a;
        endcase
    end

endmodule

>>> src/job_shop_schedule_decoder_core.sv
// Top level of the job-shop schedule decoder: sequencer, schedule state, output register.
// A schedule gene steps through routing read and max, finish add, start+1, span and emit,
// waiting in emit while the output register stays full; an overrun gene goes straight to
// emit. Input is taken only when idle, so a new item waits until the last one is through;
// the single shared time unit is stepped four times per gene. Reset (aresetn low,
// synchronous) clears all ready times, operation counters, slot counters, makespan and the
// output valid; the routing table keeps its contents and is undefined until loaded.
module job_shop_schedule_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] command, [5:2] job, [9:6] op_index, [13:10] machine_in, [21:14] duration
    input  logic [jssd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] machine_out, [12:4] slot, [28:13] start_time, [44:29] stop_time,
    // [60:45] makespan
    output logic [jssd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] overrun
    output logic                               m_axis_tuser
);

    // Unpack the input item.
    jssd_pkg::cmd_t                    in_cmd;
    logic [jssd_pkg::JOB_W-1:0]        in_job;
    logic [jssd_pkg::OP_W-1:0]         in_op;
    logic [jssd_pkg::MACH_W-1:0]       in_mach;
    logic [jssd_pkg::DUR_W-1:0]        in_dur;

    assign in_cmd  = jssd_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign in_job  = s_axis_tdata[5:2];
    assign in_op   = s_axis_tdata[9:6];
    assign in_mach = s_axis_tdata[13:10];
    assign in_dur  = s_axis_tdata[21:14];

    // Schedule state, small enough to live in flip-flops that a clear resets all together.
    logic [jssd_pkg::OPCNT_W-1:0] job_next_op_reg   [jssd_pkg::MAX_JOBS];
    logic [jssd_pkg::TIME_W-1:0]  job_ready_reg     [jssd_pkg::MAX_JOBS];
    logic [jssd_pkg::TIME_W-1:0]  machine_ready_reg [jssd_pkg::MAX_MACHINES];
    logic [jssd_pkg::SLOT_W-1:0]  machine_slots_reg [jssd_pkg::MAX_MACHINES];
    logic [jssd_pkg::TIME_W-1:0]  span_reg;

    // Sequencer and working registers for the gene in flight.
    jssd_pkg::state_t             state_reg, state_next;
    logic [jssd_pkg::JOB_W-1:0]   job_reg;
    logic [jssd_pkg::MACH_W-1:0]  mach_reg;
    logic [jssd_pkg::DUR_W-1:0]   dur_reg;
    logic [jssd_pkg::TIME_W-1:0]  start_reg;
    logic [jssd_pkg::TIME_W-1:0]  finish_reg;
    logic [jssd_pkg::TIME_W-1:0]  first_reg;
    jssd_pkg::result_t            result_reg;
    logic                         overrun_reg;

    // Output register.
    logic                         m_valid_reg;
    jssd_pkg::result_t            m_result_reg;

    logic                         accept;
    logic                         out_free;
    logic                         load_ok;
    logic                         job_done;
    logic                         ram_we;
    logic                         ram_re;
    jssd_pkg::route_t             ram_wdata;
    jssd_pkg::route_t             ram_rdata;
    logic [jssd_pkg::ROUTE_AW-1:0] ram_waddr;
    logic [jssd_pkg::ROUTE_AW-1:0] ram_raddr;
    logic [jssd_pkg::SLOT_W-1:0]  slot_new;

    jssd_pkg::alu_op_t            alu_op;
    logic [jssd_pkg::TIME_W-1:0]  alu_a;
    logic [jssd_pkg::TIME_W-1:0]  alu_b;
    logic [jssd_pkg::TIME_W-1:0]  alu_y;

    assign s_axis_tready = (state_reg == jssd_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // A job with all its operations used cannot take another gene.
    assign job_done = (job_next_op_reg[in_job] >= jssd_pkg::OPCNT_W'(jssd_pkg::MAX_OPS));

    // All field values are in range at these widths; drop anything beyond the table.
    assign load_ok = (32'(in_job) < jssd_pkg::MAX_JOBS) && (32'(in_op) < jssd_pkg::MAX_OPS)
                     && (32'(in_mach) < jssd_pkg::MAX_MACHINES);

    assign ram_we          = accept && (in_cmd == jssd_pkg::CMD_LOAD) && load_ok;
    assign ram_waddr       = {in_job, in_op};
    assign ram_wdata.machine  = in_mach;
    assign ram_wdata.duration = in_dur;
    assign ram_re          = accept && (in_cmd == jssd_pkg::CMD_SCHED) && !job_done;
    assign ram_raddr       = {in_job, job_next_op_reg[in_job][jssd_pkg::OP_W-1:0]};

    jssd_route_ram u_route_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    jssd_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign slot_new = (machine_slots_reg[mach_reg] == jssd_pkg::SLOT_MAX)
                      ? jssd_pkg::SLOT_MAX
                      : machine_slots_reg[mach_reg] + jssd_pkg::SLOT_W'(1);

    // Next state and the operands of the shared time unit.
    always_comb begin
        state_next = state_reg;
        alu_op     = jssd_pkg::ALU_MAX;
        alu_a      = job_ready_reg[job_reg];
        alu_b      = machine_ready_reg[ram_rdata.machine];
        unique case (state_reg)
            jssd_pkg::ST_IDLE: begin
                if (accept && in_cmd == jssd_pkg::CMD_SCHED) begin
                    state_next = job_done ? jssd_pkg::ST_EMIT : jssd_pkg::ST_START;
                end
            end
            jssd_pkg::ST_START: begin
                // start = later of job and machine ready times
                state_next = jssd_pkg::ST_FINISH;
            end
            jssd_pkg::ST_FINISH: begin
                alu_op     = jssd_pkg::ALU_SATADD;
                alu_a      = start_reg;
                alu_b      = jssd_pkg::TIME_W'(dur_reg);
                state_next = jssd_pkg::ST_FIRST;
            end
            jssd_pkg::ST_FIRST: begin
                alu_op     = jssd_pkg::ALU_SATADD;
                alu_a      = start_reg;
                alu_b      = jssd_pkg::TIME_W'(1);
                state_next = jssd_pkg::ST_SPAN;
            end
            jssd_pkg::ST_SPAN: begin
                alu_op     = jssd_pkg::ALU_MAX;
                alu_a      = finish_reg;
                alu_b      = span_reg;
                state_next = jssd_pkg::ST_EMIT;
            end
            jssd_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = jssd_pkg::ST_IDLE;
                end
            end
            default: state_next = jssd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jssd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers of the gene in flight.
    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg     <= in_job;
            overrun_reg <= job_done;
        end
        case (state_reg)
            jssd_pkg::ST_START: begin
                mach_reg  <= ram_rdata.machine;
                dur_reg   <= ram_rdata.duration;
                start_reg <= alu_y;
            end
            jssd_pkg::ST_FINISH: finish_reg <= alu_y;
            jssd_pkg::ST_FIRST:  first_reg  <= alu_y;
            jssd_pkg::ST_SPAN: begin
                result_reg.overrun    <= 1'b0;
                result_reg.makespan   <= alu_y;
                result_reg.stop_time  <= finish_reg;
                result_reg.start_time <= first_reg;
                result_reg.slot       <= slot_new;
                result_reg.machine    <= mach_reg;
            end
            default: ;
        endcase
    end

    // Schedule state: clear on reset or command, update on commit.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_cmd == jssd_pkg::CMD_CLEAR)) begin
            for (int i = 0; i < jssd_pkg::MAX_JOBS; i++) begin
                job_next_op_reg[i] <= '0;
                job_ready_reg[i]   <= '0;
            end
            for (int i = 0; i < jssd_pkg::MAX_MACHINES; i++) begin
                machine_ready_reg[i] <= '0;
                machine_slots_reg[i] <= '0;
            end
            span_reg <= '0;
        end else if (state_reg == jssd_pkg::ST_SPAN) begin
            job_next_op_reg[job_reg]    <= job_next_op_reg[job_reg] + jssd_pkg::OPCNT_W'(1);
            job_ready_reg[job_reg]      <= finish_reg;
            machine_ready_reg[mach_reg] <= finish_reg;
            machine_slots_reg[mach_reg] <= slot_new;
            span_reg                    <= alu_y;
        end
    end

    // Output register: load when the slot is empty or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == jssd_pkg::ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == jssd_pkg::ST_EMIT && out_free) begin
            if (overrun_reg) begin
                // Out of operations: report the overrun flag and the current span, nothing else.
                m_result_reg <= {1'b1, span_reg,
                                 {(2 * jssd_pkg::TIME_W + jssd_pkg::SLOT_W
                                   + jssd_pkg::MACH_W){1'b0}}};
            end else begin
                m_result_reg <= result_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_result_reg.overrun;
    assign m_axis_tdata  = {3'b000, m_result_reg.makespan, m_result_reg.stop_time,
                            m_result_reg.start_time, m_result_reg.slot, m_result_reg.machine};

endmodule

>>> test/jssd_sched_check_pkg.sv
// Schedule predictor and result checker for the job-shop decoder testbench.
package jssd_sched_check_pkg;

    import jssd_pkg::*;

    class schedule_checker;

        logic [MACH_W-1:0]  route_mach   [ROUTE_DEPTH];
        logic [DUR_W-1:0]   route_dur    [ROUTE_DEPTH];
        bit                 route_loaded [ROUTE_DEPTH];
        logic [OPCNT_W-1:0] next_op      [MAX_JOBS];
        logic [TIME_W-1:0]  job_ready    [MAX_JOBS];
        logic [TIME_W-1:0]  mach_ready   [MAX_MACHINES];
        logic [SLOT_W-1:0]  mach_slots   [MAX_MACHINES];
        logic [TIME_W-1:0]  span;

        result_t pending_genes[$];

        int mismatches;
        int results_seen;
        int loads;
        int clears;
        int genes;
        int overruns;
        int idle_cmds;

        function new();
            for (int i = 0; i < ROUTE_DEPTH; i++) begin
                route_mach[i]   = '0;
                route_dur[i]    = '0;
                route_loaded[i] = 1'b0;
            end
            clear_schedule();
        endfunction

        function void clear_schedule();
            for (int j = 0; j < MAX_JOBS; j++) begin
                next_op[j]   = '0;
                job_ready[j] = '0;
            end
            for (int m = 0; m < MAX_MACHINES; m++) begin
                mach_ready[m] = '0;
                mach_slots[m] = '0;
            end
            span = '0;
        endfunction

        function int ops_done(logic [JOB_W-1:0] job);
            return int'(next_op[job]);
        endfunction

        // a gene may only be issued if it overruns or its routing entry is loaded
        function bit gene_ok(logic [JOB_W-1:0] job);
            if (next_op[job] >= MAX_OPS)
                return 1'b1;
            return route_loaded[{job, next_op[job][OP_W-1:0]}];
        endfunction

        function int pending();
            return pending_genes.size();
        endfunction

        // decode one accepted input item into its expected result, if any
        function void note_item(logic [S_TDATA_W-1:0] word);
            cmd_t               cmd;
            logic [JOB_W-1:0]   job;
            logic [OP_W-1:0]    op;
            logic [MACH_W-1:0]  mach;
            logic [DUR_W-1:0]   dur;
            logic [ROUTE_AW-1:0] addr;
            logic [MACH_W-1:0]  m;
            logic [TIME_W-1:0]  start;
            logic [TIME_W-1:0]  finish;
            logic [TIME_W:0]    sum;
            result_t            res;
            cmd  = cmd_t'(word[1:0]);
            job  = word[5:2];
            op   = word[9:6];
            mach = word[13:10];
            dur  = word[21:14];
            case (cmd)
                CMD_LOAD: begin
                    addr = {job, op};
                    route_mach[addr]   = mach;
                    route_dur[addr]    = dur;
                    route_loaded[addr] = 1'b1;
                    loads++;
                end
                CMD_CLEAR: begin
                    clear_schedule();
                    clears++;
                end
                CMD_SCHED: begin
                    genes++;
                    res = '0;
                    if (next_op[job] >= MAX_OPS) begin
                        res.makespan = span;
                        res.overrun  = 1'b1;
                        overruns++;
                    end else begin
                        addr = {job, next_op[job][OP_W-1:0]};
                        m    = route_mach[addr];
                        next_op[job] = next_op[job] + OPCNT_W'(1);
                        start = (job_ready[job] > mach_ready[m]) ? job_ready[job] : mach_ready[m];
                        sum    = {1'b0, start} + (TIME_W + 1)'(route_dur[addr]);
                        finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                        if (mach_slots[m] != SLOT_MAX)
                            mach_slots[m] = mach_slots[m] + SLOT_W'(1);
                        job_ready[job] = finish;
                        mach_ready[m]  = finish;
                        if (finish > span)
                            span = finish;
                        sum = {1'b0, start} + (TIME_W + 1)'(1);
                        res.machine    = m;
                        res.slot       = mach_slots[m];
                        res.start_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                        res.stop_time  = finish;
                        res.makespan   = span;
                    end
                    pending_genes.push_back(res);
                end
                default: idle_cmds++;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_gene_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            result_t got;
            result_t want;
            got = {tuser, tdata[60:0]};
            results_seen++;
            if (pending_genes.size() == 0) begin
                report($sformatf("result with none expected: tdata %h tuser %b", tdata, tuser));
                return;
            end
            want = pending_genes.pop_front();
            if (got.machine != want.machine || got.slot != want.slot
                    || got.start_time != want.start_time || got.stop_time != want.stop_time
                    || got.makespan != want.makespan || got.overrun != want.overrun)
                report($sformatf({"result %0d exp/act: mach %0d/%0d slot %0d/%0d ",
                                  "start %0d/%0d stop %0d/%0d span %0d/%0d ovr %0d/%0d"},
                                 results_seen, want.machine, got.machine, want.slot, got.slot,
                                 want.start_time, got.start_time, want.stop_time,
                                 got.stop_time, want.makespan, got.makespan,
                                 want.overrun, got.overrun));
        endfunction

    endclass

endpackage

>>> test/tb_job_shop_schedule_decoder_core.sv
// Self-checking testbench for the job-shop schedule decoder core.
module tb_job_shop_schedule_decoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    import jssd_pkg::*;
    import jssd_sched_check_pkg::*;

    localparam int N_RANDOM    = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    logic hold_off = 1'b0;
    bit   tx_gappy = 1'b0;
    bit   rx_gappy = 1'b1;
    int   rx_gap   = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;

    schedule_checker sb = new();

    job_shop_schedule_decoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Offer one item and hold it until accepted; called at a rising edge.
    // A gap, if drawn, drops tvalid first; otherwise tvalid stays high into the next item.
    task automatic send_item(input cmd_t cmd, input logic [JOB_W-1:0] job,
                             input logic [OP_W-1:0] op, input logic [MACH_W-1:0] mach,
                             input logic [DUR_W-1:0] dur);
        int gap;
        gap = tx_gappy ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, dur, mach, op, job, cmd};
        do @(posedge aclk); while (!s_axis_tready);
        // accepted at this edge: predict its result now, in order
        sb.note_item({2'b00, dur, mach, op, job, cmd});
        items_sent++;
    endtask

    // Receiver: check each accepted result, then draw a stall before the next one.
    // The stall mode flips now and then so that long runs without stalls occur too.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_gene_result(m_axis_tdata, m_axis_tuser);
                if ($urandom_range(0, 15) == 0)
                    rx_gappy = !rx_gappy;
                rx_gap = rx_gappy ? $urandom_range(0, 3) : 0;
            end else if (rx_gap > 0 && !m_axis_tready) begin
                rx_gap--;
            end
            m_axis_tready <= !hold_off && rx_gap == 0;
        end
    end

    // Hold off the receiver for a long stretch mid-run so the block backs up
    // and stalls its input while the sender keeps offering items.
    initial begin
        wait (items_sent >= 250);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int        ep;
        int        rand_items;
        int        n_jobs;
        int        n_ops;
        int        first;
        int        genes_left;
        int        mach_hi;
        int        noise;
        int        tries;
        bit        found;
        logic [JOB_W-1:0] pick;
        logic [DUR_W-1:0] dur;
        logic [JOB_W-1:0] ep_jobs [4];

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, a zero-length operation, a machine conflict,
        // an idle command with all fields set and a clear that keeps the routing.
        send_item(CMD_LOAD,  4'd0,  4'd0,  4'd0,  8'd0);
        send_item(CMD_LOAD,  4'd15, 4'd15, 4'd15, 8'd255);
        send_item(CMD_LOAD,  4'd15, 4'd0,  4'd15, 8'd255);
        send_item(CMD_LOAD,  4'd0,  4'd1,  4'd15, 8'd1);
        send_item(CMD_NOP,   4'd15, 4'd15, 4'd15, 8'd255);
        send_item(CMD_SCHED, 4'd0,  4'd0,  4'd0,  8'd0);
        send_item(CMD_SCHED, 4'd15, 4'd15, 4'd15, 8'd255);
        // job 0 op 1 must wait for machine 15
        send_item(CMD_SCHED, 4'd0,  4'd0,  4'd0,  8'd0);
        send_item(CMD_CLEAR, 4'd15, 4'd15, 4'd15, 8'd255);
        send_item(CMD_SCHED, 4'd0,  4'd15, 4'd15, 8'd255);
        send_item(CMD_SCHED, 4'd0,  4'd0,  4'd0,  8'd0);
        send_item(CMD_SCHED, 4'd15, 4'd0,  4'd0,  8'd0);
        send_item(CMD_NOP,   4'd0,  4'd0,  4'd0,  8'd0);

        // Random: episodes of routing loads followed by genes for those jobs,
        // with idle commands, stray loads and early clears mixed in as noise.
        ep = 0;
        rand_items = 0;
        while (rand_items < N_RANDOM) begin
            tx_gappy = $urandom_range(0, 3) != 0;
            mach_hi  = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 15);
            if ($urandom_range(0, 1) == 0) begin
                send_item(CMD_CLEAR, JOB_W'($urandom_range(0, 15)),
                          OP_W'($urandom_range(0, 15)), MACH_W'($urandom_range(0, 15)),
                          DUR_W'($urandom_range(0, 255)));
                rand_items++;
            end
            n_jobs = $urandom_range(1, 4);
            genes_left = 0;
            for (int k = 0; k < n_jobs; k++) begin
                ep_jobs[k] = JOB_W'($urandom_range(0, 15));
                // a full routing lets the job run out of operations later
                n_ops = (ep == 0 || $urandom_range(0, 2) == 0) ? 16 : $urandom_range(1, 15);
                first = sb.ops_done(ep_jobs[k]);
                for (int op = first; op < MAX_OPS && op < first + n_ops; op++) begin
                    dur = ($urandom_range(0, 7) == 0) ? DUR_W'($urandom_range(0, 255))
                                                      : DUR_W'($urandom_range(0, 31));
                    send_item(CMD_LOAD, ep_jobs[k], OP_W'(op),
                              MACH_W'($urandom_range(0, mach_hi)), dur);
                    rand_items++;
                end
                genes_left += n_ops;
            end
            genes_left += $urandom_range(0, 4);
            repeat (genes_left) begin
                noise = $urandom_range(0, 39);
                if (noise == 0) begin
                    send_item(CMD_NOP, JOB_W'($urandom_range(0, 15)),
                              OP_W'($urandom_range(0, 15)), MACH_W'($urandom_range(0, 15)),
                              DUR_W'($urandom_range(0, 255)));
                end else if (noise == 1) begin
                    send_item(CMD_CLEAR, JOB_W'($urandom_range(0, 15)),
                              OP_W'($urandom_range(0, 15)), MACH_W'($urandom_range(0, 15)),
                              DUR_W'($urandom_range(0, 255)));
                    rand_items++;
                end else if (noise < 4) begin
                    send_item(CMD_LOAD, JOB_W'($urandom_range(0, 15)),
                              OP_W'($urandom_range(0, 15)), MACH_W'($urandom_range(0, 15)),
                              DUR_W'($urandom_range(0, 255)));
                    rand_items++;
                end
                // skip genes that would read a routing entry never loaded
                found = 1'b0;
                pick  = '0;
                for (tries = 0; tries < 8 && !found; tries++) begin
                    pick  = ($urandom_range(0, 3) != 0)
                            ? ep_jobs[2'($urandom_range(0, n_jobs - 1))]
                            : JOB_W'($urandom_range(0, 15));
                    found = sb.gene_ok(pick);
                end
                if (found) begin
                    send_item(CMD_SCHED, pick, OP_W'($urandom_range(0, 15)),
                              MACH_W'($urandom_range(0, 15)), DUR_W'($urandom_range(0, 255)));
                    rand_items++;
                end
            end
            ep++;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep watching for any stray result
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d items in %0d episodes: %0d loads, %0d clears, %0d idle commands",
                 items_sent, ep, sb.loads, sb.clears, sb.idle_cmds);
        $display("Checked %0d gene results (%0d overruns), %0d mismatches",
                 sb.results_seen, sb.overruns, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
